// ===== hw/rtl/saf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saf_pkg: shared definitions for the ASCII STL facet counter
// Keyword codes, counter widths, configuration register indexes and the
// structs for configuration, the items from the input stage to the core and results.
// ----------------------------------------------------------------------------
package saf_pkg;

  localparam int unsigned SIZE_BITS     = 48;
  localparam int unsigned COUNT_BITS    = 32;
  localparam int unsigned BYTE_TOTAL_W  = 48;
  localparam int unsigned FACET_TOTAL_W = 32;

  localparam int unsigned WIN_BYTES = 8;
  localparam int unsigned WIN_W     = 8 * WIN_BYTES;
  localparam int unsigned FILL_W    = $clog2(WIN_BYTES + 1);

  // "endfacet" and "endsolid", first character in the high byte.
  localparam logic [WIN_W-1:0] KEY_FACET = 64'h656E_6466_6163_6574;
  localparam logic [WIN_W-1:0] KEY_SOLID = 64'h656E_6473_6F6C_6964;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_EN  = 2'd0,
    CFG_FACET_EN = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic size_enable;
    logic facet_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_last;
  } item_t;

  typedef struct packed {
    logic [BYTE_TOTAL_W-1:0]  byte_total;
    logic [FACET_TOTAL_W-1:0] facet_total;
    logic                     terminator_seen;
  } result_t;

endpackage

// ===== hw/rtl/saf_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saf_in_stage: input register
// Holds one accepted stream byte for the match core. A new request is taken
// whenever the register is empty or the core takes the held byte.
// ----------------------------------------------------------------------------
module saf_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  saf_pkg::item_t in_item_i,
  output logic           item_valid_o,
  input  logic           item_ready_i,
  output saf_pkg::item_t item_o
);
  import saf_pkg::*;

  logic  valid_q;
  logic  valid_d;
  item_t item_q;
  logic  load;

  assign in_ready_o = !valid_q || item_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== hw/rtl/saf_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saf_core: keyword matcher, counters and result register
// Shifts each byte up to endsolid into an eight-byte window, compares it with
// both keywords, updates the saturating counters and registers one result.
// ----------------------------------------------------------------------------
module saf_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  saf_pkg::cfg_t    cfg_i,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  saf_pkg::item_t   item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output saf_pkg::result_t result_o
);
  import saf_pkg::*;

  localparam logic [SIZE_BITS-1:0]  SIZE_MAX  = {SIZE_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [WIN_W-1:0]      win_q, win_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [SIZE_BITS-1:0]  byte_cnt_q, byte_cnt_d;
  logic [COUNT_BITS-1:0] facet_cnt_q, facet_cnt_d;
  logic                  done_q, done_d;
  logic                  out_valid_q, out_valid_d;
  result_t               result_q, result_d;

  logic                  fire;
  logic [WIN_W-1:0]      win_next;
  logic                  win_full;
  logic                  is_facet;
  logic                  is_solid;
  logic                  emit;
  logic                  emit_term;
  logic                  clear;
  logic [SIZE_BITS-1:0]  byte_cnt_upd;
  logic [COUNT_BITS-1:0] facet_cnt_upd;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign fire         = item_valid_i && item_ready_o;

  // The window counts as full once the incoming byte is the eighth one.
  assign win_next = {win_q[WIN_W-9:0], item_i.data_byte};
  assign win_full = fill_q >= FILL_W'(WIN_BYTES - 1);
  assign is_facet = win_full && (win_next == KEY_FACET);
  assign is_solid = win_full && (win_next == KEY_SOLID);

  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    byte_cnt_d  = byte_cnt_q;
    facet_cnt_d = facet_cnt_q;
    done_d      = done_q;
    emit        = 1'b0;
    emit_term   = 1'b0;
    clear       = 1'b0;

    if (fire) begin
      if (done_q) begin
        // Bytes after endsolid are dropped; the last one re-arms the block.
        clear = item_i.stream_last;
      end else begin
        win_d = win_next;
        if (fill_q != FILL_W'(WIN_BYTES)) begin
          fill_d = fill_q + FILL_W'(1);
        end
        if (cfg_i.size_enable && byte_cnt_q != SIZE_MAX) begin
          byte_cnt_d = byte_cnt_q + SIZE_BITS'(1);
        end
        if (is_facet && cfg_i.facet_enable && facet_cnt_q != COUNT_MAX) begin
          facet_cnt_d = facet_cnt_q + COUNT_BITS'(1);
        end
        if (is_solid) begin
          emit      = 1'b1;
          emit_term = 1'b1;
          clear     = item_i.stream_last;
          done_d    = !item_i.stream_last;
        end else if (item_i.stream_last) begin
          emit  = 1'b1;
          clear = 1'b1;
        end
      end
    end

    // A result carries the counts after this byte, before a re-arm clears them.
    byte_cnt_upd  = byte_cnt_d;
    facet_cnt_upd = facet_cnt_d;

    if (clear) begin
      win_d       = '0;
      fill_d      = '0;
      byte_cnt_d  = '0;
      facet_cnt_d = '0;
      done_d      = 1'b0;
    end
  end

  always_comb begin
    result_d                 = result_q;
    result_d.byte_total      = cfg_i.size_enable ? BYTE_TOTAL_W'(byte_cnt_upd) : '0;
    result_d.facet_total     = cfg_i.facet_enable ?
                               FACET_TOTAL_W'(facet_cnt_upd) : '0;
    result_d.terminator_seen = emit_term;

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      fill_q      <= '0;
      byte_cnt_q  <= '0;
      facet_cnt_q <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      fill_q      <= fill_d;
      byte_cnt_q  <= byte_cnt_d;
      facet_cnt_q <= facet_cnt_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  a_solid_arms_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !done_q && is_solid && !item_i.stream_last) |=> done_q)
    else $error("endsolid did not set the done flag");

  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && item_i.stream_last) |=>
      (fill_q == '0 && !done_q && byte_cnt_q == '0 && facet_cnt_q == '0))
    else $error("stream state not cleared after the last byte");

  a_done_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && done_q && !out_valid_q) |=> !out_valid_q)
    else $error("result produced for a byte after endsolid");

  a_done_holds_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> (facet_cnt_q == $past(facet_cnt_q) || facet_cnt_q == '0))
    else $error("facet count moved after endsolid");

endmodule

// ===== hw/rtl/stl_ascii_facet_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_ascii_facet_counter: ASCII STL facet and size counter
// A result reaches the output through the input register and then the result
// register after the byte that causes it is accepted, when the output is free.
// Throughput: one byte per cycle while the output is not held, set by the window
// compare and counter update in the match core.
// Reset clears the window, counters and done flag and sets both enables.
// ----------------------------------------------------------------------------
module stl_ascii_facet_counter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [saf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic                                cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          data_byte_i,
  input  logic                                stream_last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [saf_pkg::BYTE_TOTAL_W-1:0]    byte_total_o,
  output logic [saf_pkg::FACET_TOTAL_W-1:0]   facet_total_o,
  output logic                                terminator_seen_o
);
  import saf_pkg::*;

  cfg_t    cfg_q, cfg_d;
  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    item_ready;
  result_t result;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SIZE_EN:  cfg_d.size_enable  = cfg_data_i;
        CFG_FACET_EN: cfg_d.facet_enable = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{size_enable: 1'b1, facet_enable: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_item.data_byte   = data_byte_i;
  assign in_item.stream_last = stream_last_i;

  saf_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  saf_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign byte_total_o      = result.byte_total;
  assign facet_total_o     = result.facet_total;
  assign terminator_seen_o = result.terminator_seen;

endmodule
